### hdl/lldp_frame_tlv_extractor_top_assert.svh
// assertion macros for the lldp tlv extractor
`ifndef LLDP_FRAME_TLV_EXTRACTOR_TOP_ASSERT_SVH
`define LLDP_FRAME_TLV_EXTRACTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define LFT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, checked outside reset
`define LFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define LFT_ASSERT_IMP(label, ante, cons)
`define LFT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hdl/lft_pkg.sv
// shared types and constants for the lldp tlv extractor
`default_nettype none

package lft_pkg;

    // frame position counter width, enough for the largest size bound
    localparam int POS_W = 11;

    // header layout
    localparam logic [POS_W-1:0] HDR_BYTES    = 11'd14;
    localparam logic [POS_W-1:0] POS_ETYPE_HI = 11'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO = 11'd13;
    localparam logic [POS_W-1:0] POS_DA_END   = 11'd6;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ETHERTYPE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDR = 1'b1;

    // configuration reset values
    localparam logic [15:0] ETHERTYPE_RST = 16'h88CC;
    localparam logic [47:0] DEST_ADDR_RST = 48'h0180C200000E;

    // tlv kinds and subtypes
    localparam logic [6:0] TLV_END     = 7'd0;
    localparam logic [6:0] TLV_CHASSIS = 7'd1;
    localparam logic [6:0] TLV_PORT    = 7'd2;
    localparam logic [6:0] TLV_TTL     = 7'd3;
    localparam logic [7:0] CHASSIS_SUB_MAC = 8'd4;
    localparam logic [7:0] PORT_SUB_ID     = 8'd3;

    // value bytes kept per tlv
    localparam logic [8:0] KEEP_BYTES = 9'd7;

    // queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // tlv walk phase
    typedef enum logic [1:0] {
        PH_HDR_HI,
        PH_HDR_LO,
        PH_VALUE
    } phase_t;

    // configuration registers
    typedef struct packed {
        logic [15:0] ethertype;
        logic [47:0] dest_addr;
    } cfg_t;

    // classified byte passed from the front to the back
    typedef struct packed {
        logic [7:0] data;
        logic       walk;   // byte belongs to the tlv area
        logic       last;   // final byte of the frame
        logic       ok;     // frame passed header checks (valid with last)
    } item_t;

    // result item, first field in the highest bits
    typedef struct packed {
        logic [15:0] time_to_live;
        logic [31:0] port_value;
        logic        port_valid;
        logic [47:0] chassis_mac;
        logic        chassis_valid;
    } result_t;

endpackage

`default_nettype wire

### hdl/lldp_frame_tlv_extractor_top.sv
// Top level of the LLDP TLV extractor.
// Frame bytes enter on the s_ group, one byte per transfer, with s_tlast on
// the final byte. A frame passes when it has at least 14 bytes and its
// destination address and ethertype equal the configured values; its TLVs
// are then walked for the MAC chassis ID, the subtype-3 port ID and the TTL.
// One result per passing frame leaves on the m_ group; failing frames give
// none. Bytes beyond MAX_FRAME_BYTES are dropped, their s_tlast still ends
// the frame.
// Throughput: one byte per cycle while the queue has room, set by the
// byte-wide front compare and the single-step TLV walk. With the queue empty,
// the final byte is queued, then its result registered and shown on m_tvalid.
// A four-entry queue sits between the header front and the TLV back part.
// When the receiver stalls, the result is held in the output register and
// the back part keeps walking following frames until it meets another final
// byte; s_tready drops only once the queue is full.
// Reset clears all frame state and loads the default ethertype 0x88CC and
// address 01-80-C2-00-00-0E; configuration writes take effect at once; the
// user makes them only while the block is idle, which the block does not enforce.
`default_nettype none

module lldp_frame_tlv_extractor_top #(
    parameter int MAX_FRAME_BYTES = 1600
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lft_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [47:0]                     cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // data_byte
    input  wire logic                            s_tlast,   // last_byte
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // chassis_valid, chassis_mac, port_valid, port_value, time_to_live, zero pad
    output logic [103:0]                         m_tdata
);

    lft_pkg::cfg_t     cfg_reg;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    lft_pkg::item_t    push_item;
    lft_pkg::item_t    q_item;
    lft_pkg::result_t  result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ethertype <= lft_pkg::ETHERTYPE_RST;
            cfg_reg.dest_addr <= lft_pkg::DEST_ADDR_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lft_pkg::CFG_ETHERTYPE: cfg_reg.ethertype <= cfg_wr_data[15:0];
                lft_pkg::CFG_DEST_ADDR: cfg_reg.dest_addr <= cfg_wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // header check and byte classification
    lft_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // decoupling queue
    lft_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_item)
    );

    // tlv walk and result register
    lft_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = {6'b0, result};

    // checks
    `include "lldp_frame_tlv_extractor_top_assert.svh"

    `LFT_ASSERT_IMP(a_pop_needs_entry, q_pop, q_valid)
    `LFT_ASSERT_IMP(a_stall_only_when_queued, !s_tready, q_valid)
    `LFT_ASSERT_NEXT(a_passing_frame_gives_result, q_pop && q_item.last && q_item.ok, m_tvalid)

endmodule

`default_nettype wire

### hdl/lft_front.sv
// front part: counts frame bytes, checks the header and classifies each byte
`default_nettype none

module lft_front #(
    parameter int MAX_FRAME_BYTES = 1600
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lft_pkg::cfg_t   cfg,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,
    input  wire logic            s_tlast,
    input  wire logic            q_full,
    output logic                 q_push,
    output lft_pkg::item_t       q_item
);

    localparam logic [lft_pkg::POS_W-1:0] MAX_POS = lft_pkg::POS_W'(MAX_FRAME_BYTES);

    logic [lft_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      match_reg, match_next;
    logic                      accept;
    logic                      in_range;
    logic                      byte_ok;
    logic [7:0]                want;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign in_range = pos_reg < MAX_POS;

    // expected destination address byte, first byte most significant
    always_comb
    begin
        case (pos_reg[2:0])
            3'd0:    want = cfg.dest_addr[47:40];
            3'd1:    want = cfg.dest_addr[39:32];
            3'd2:    want = cfg.dest_addr[31:24];
            3'd3:    want = cfg.dest_addr[23:16];
            3'd4:    want = cfg.dest_addr[15:8];
            default: want = cfg.dest_addr[7:0];
        endcase
    end

    // header compare for the current byte
    always_comb
    begin
        byte_ok = 1'b1;
        if (in_range)
        begin
            if (pos_reg < lft_pkg::POS_DA_END)
            begin
                byte_ok = (s_tdata == want);
            end
            else if (pos_reg == lft_pkg::POS_ETYPE_HI)
            begin
                byte_ok = (s_tdata == cfg.ethertype[15:8]);
            end
            else if (pos_reg == lft_pkg::POS_ETYPE_LO)
            begin
                byte_ok = (s_tdata == cfg.ethertype[7:0]);
            end
        end
    end

    // classification and per-frame counters
    always_comb
    begin
        pos_next   = in_range ? pos_reg + 1'b1 : pos_reg;
        match_next = match_reg && byte_ok;

        q_item.data = s_tdata;
        q_item.walk = in_range && (pos_reg >= lft_pkg::HDR_BYTES);
        q_item.last = s_tlast;
        q_item.ok   = match_next && (pos_next >= lft_pkg::HDR_BYTES);
        q_push      = accept && (q_item.walk || s_tlast);

        if (s_tlast)
        begin
            pos_next   = '0;
            match_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            match_reg <= 1'b1;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            match_reg <= match_next;
        end
    end

endmodule

`default_nettype wire

### hdl/lft_queue.sv
// short queue of classified bytes between the front and back parts
`default_nettype none

module lft_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire lft_pkg::item_t   push_item,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output lft_pkg::item_t        head
);

    lft_pkg::item_t                entry_reg [lft_pkg::QUEUE_DEPTH];
    logic [lft_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [lft_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [lft_pkg::QCNT_W-1:0]    count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == lft_pkg::QCNT_W'(lft_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/lft_back.sv
// back part: walks the tlvs, holds captured fields and registers the result
`default_nettype none

module lft_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire lft_pkg::item_t   q_item,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output lft_pkg::result_t      m_result
);

    lft_pkg::phase_t   phase_reg, phase_next;
    logic [7:0]        hdr_hi_reg, hdr_hi_next;
    logic [6:0]        kind_reg, kind_next;
    logic [8:0]        remain_reg, remain_next;
    logic [8:0]        length_reg, length_next;
    logic [55:0]       shift_reg, shift_next;
    logic [55:0]       shift_val;
    logic              stopped_reg, stopped_next;
    logic [47:0]       chassis_reg, chassis_next;
    logic              chassis_seen_reg, chassis_seen_next;
    logic [31:0]       port_reg, port_next;
    logic              port_seen_reg, port_seen_next;
    logic [15:0]       ttl_reg, ttl_next;
    logic              commit;
    logic [7:0]        port_sub;
    logic [31:0]       port_id;
    logic              out_free;
    logic              load_out;
    logic              out_valid_reg;
    lft_pkg::result_t  out_reg;
    lft_pkg::result_t  result_now;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = q_valid && (!q_item.last || out_free);
    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

    // kept value bytes including the one at the queue head
    assign shift_val = ((length_reg - remain_reg) < lft_pkg::KEEP_BYTES) ?
                       {shift_reg[47:0], q_item.data} : shift_reg;

    // port id position depends on how many value bytes were kept
    always_comb
    begin
        if (length_reg >= lft_pkg::KEEP_BYTES)
        begin
            port_sub = shift_val[55:48];
            port_id  = shift_val[47:16];
        end
        else if (length_reg == 9'd6)
        begin
            port_sub = shift_val[47:40];
            port_id  = shift_val[39:8];
        end
        else
        begin
            port_sub = shift_val[39:32];
            port_id  = shift_val[31:0];
        end
    end

    // tlv walk
    always_comb
    begin
        phase_next        = phase_reg;
        hdr_hi_next       = hdr_hi_reg;
        kind_next         = kind_reg;
        remain_next       = remain_reg;
        length_next       = length_reg;
        shift_next        = shift_reg;
        stopped_next      = stopped_reg;
        chassis_next      = chassis_reg;
        chassis_seen_next = chassis_seen_reg;
        port_next         = port_reg;
        port_seen_next    = port_seen_reg;
        ttl_next          = ttl_reg;
        commit            = 1'b0;
        load_out          = 1'b0;

        if (q_pop && q_item.walk && !stopped_reg)
        begin
            unique case (phase_reg)
                lft_pkg::PH_HDR_HI:
                begin
                    hdr_hi_next = q_item.data;
                    phase_next  = lft_pkg::PH_HDR_LO;
                end
                lft_pkg::PH_HDR_LO:
                begin
                    kind_next   = hdr_hi_reg[7:1];
                    length_next = {hdr_hi_reg[0], q_item.data};
                    remain_next = {hdr_hi_reg[0], q_item.data};
                    shift_next  = '0;
                    if (hdr_hi_reg[7:1] == lft_pkg::TLV_END)
                    begin
                        stopped_next = 1'b1;
                        phase_next   = lft_pkg::PH_HDR_HI;
                    end
                    else if ({hdr_hi_reg[0], q_item.data} == 9'd0)
                    begin
                        // empty tlv: nothing can be captured from it
                        phase_next = lft_pkg::PH_HDR_HI;
                    end
                    else
                    begin
                        phase_next = lft_pkg::PH_VALUE;
                    end
                end
                default:
                begin
                    shift_next  = shift_val;
                    remain_next = remain_reg - 1'b1;
                    commit      = (remain_reg == 9'd1);
                end
            endcase
        end

        // complete tlv: capture the field it carries
        if (commit)
        begin
            unique case (kind_reg)
                lft_pkg::TLV_CHASSIS:
                begin
                    if (length_reg >= lft_pkg::KEEP_BYTES &&
                        shift_val[55:48] == lft_pkg::CHASSIS_SUB_MAC)
                    begin
                        chassis_next      = shift_val[47:0];
                        chassis_seen_next = 1'b1;
                    end
                end
                lft_pkg::TLV_PORT:
                begin
                    if (length_reg >= 9'd5 && port_sub == lft_pkg::PORT_SUB_ID)
                    begin
                        port_next      = port_id;
                        port_seen_next = 1'b1;
                    end
                end
                lft_pkg::TLV_TTL:
                begin
                    if (length_reg == 9'd2)
                    begin
                        ttl_next = shift_val[15:0];
                    end
                end
                default:
                begin
                end
            endcase
            phase_next = lft_pkg::PH_HDR_HI;
            shift_next = '0;
        end

        result_now.chassis_valid = chassis_seen_next;
        result_now.chassis_mac   = chassis_next;
        result_now.port_valid    = port_seen_next;
        result_now.port_value    = port_next;
        result_now.time_to_live  = ttl_next;

        // frame end: give the result if the header passed, then clear
        if (q_pop && q_item.last)
        begin
            load_out          = q_item.ok;
            phase_next        = lft_pkg::PH_HDR_HI;
            hdr_hi_next       = '0;
            kind_next         = '0;
            remain_next       = '0;
            length_next       = '0;
            shift_next        = '0;
            stopped_next      = 1'b0;
            chassis_next      = '0;
            chassis_seen_next = 1'b0;
            port_next         = '0;
            port_seen_next    = 1'b0;
            ttl_next          = '0;
        end
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lft_pkg::PH_HDR_HI;
            hdr_hi_reg       <= '0;
            kind_reg         <= '0;
            remain_reg       <= '0;
            length_reg       <= '0;
            shift_reg        <= '0;
            stopped_reg      <= 1'b0;
            chassis_reg      <= '0;
            chassis_seen_reg <= 1'b0;
            port_reg         <= '0;
            port_seen_reg    <= 1'b0;
            ttl_reg          <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            hdr_hi_reg       <= hdr_hi_next;
            kind_reg         <= kind_next;
            remain_reg       <= remain_next;
            length_reg       <= length_next;
            shift_reg        <= shift_next;
            stopped_reg      <= stopped_next;
            chassis_reg      <= chassis_next;
            chassis_seen_reg <= chassis_seen_next;
            port_reg         <= port_next;
            port_seen_reg    <= port_seen_next;
            ttl_reg          <= ttl_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= result_now;
        end
    end

endmodule

`default_nettype wire

### bench/lldp_summary_checker.sv
// checker for the lldp tlv extractor: predicts each frame summary and compares
module lldp_summary_checker #(
    parameter int MAX_FRAME_BYTES = 1600
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [47:0]                   cfg_wr_data,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [7:0]                    s_tdata,    // data_byte
    input  wire logic                          s_tlast,    // last_byte
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // chassis_valid, chassis_mac, port_valid, port_value, time_to_live, zero pad
    input  wire logic [103:0]                  m_tdata,
    output int                                 mismatches,
    output int                                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8:0] PORT_ID_MIN_LEN = 9'd5;
    localparam logic [8:0] TTL_LEN         = 9'd2;

    // register copies
    logic [15:0] want_etype;
    logic [47:0] want_dest;

    // per-frame parse state
    logic [lft_pkg::POS_W-1:0] pos;
    logic                      hdr_ok;
    lft_pkg::phase_t           phase;
    logic [7:0]                head_hi;
    logic [6:0]                kind;
    logic [8:0]                remain;
    logic [8:0]                tlen;
    logic [63:0]               value_bytes;
    logic                      stopped;
    logic [47:0]               chassis;
    logic                      chassis_ok;
    logic [31:0]               port;
    logic                      port_ok;
    logic [15:0]               ttl;

    lft_pkg::result_t expected_summaries[$];

    task automatic start_new_frame();
        pos         = '0;
        hdr_ok      = 1'b1;
        phase       = lft_pkg::PH_HDR_HI;
        head_hi     = '0;
        kind        = '0;
        remain      = '0;
        tlen        = '0;
        value_bytes = '0;
        stopped     = 1'b0;
        chassis     = '0;
        chassis_ok  = 1'b0;
        port        = '0;
        port_ok     = 1'b0;
        ttl         = '0;
    endtask

    // a tlv whose value is complete: take what it carries
    task automatic close_tlv();
        logic [8:0] kept;
        int         k;
        kept = (tlen < lft_pkg::KEEP_BYTES) ? tlen : lft_pkg::KEEP_BYTES;
        k    = int'(kept);
        if (kind == lft_pkg::TLV_END)
        begin
            stopped = 1'b1;
        end
        else if (kind == lft_pkg::TLV_CHASSIS)
        begin
            if (tlen >= lft_pkg::KEEP_BYTES &&
                value_bytes[55:48] == lft_pkg::CHASSIS_SUB_MAC)
            begin
                chassis    = value_bytes[47:0];
                chassis_ok = 1'b1;
            end
        end
        else if (kind == lft_pkg::TLV_PORT)
        begin
            // subtype is the oldest kept byte, id the four after it
            if (tlen >= PORT_ID_MIN_LEN)
            begin
                if (value_bytes[8*(k-1) +: 8] == lft_pkg::PORT_SUB_ID)
                begin
                    port    = value_bytes[8*(k-5) +: 32];
                    port_ok = 1'b1;
                end
            end
        end
        else if (kind == lft_pkg::TLV_TTL)
        begin
            if (tlen == TTL_LEN)
                ttl = value_bytes[15:0];
        end
        phase       = lft_pkg::PH_HDR_HI;
        value_bytes = '0;
    endtask

    // one byte of the tlv area
    task automatic walk_tlv_byte(input logic [7:0] b);
        if (!stopped)
        begin
            case (phase)
                lft_pkg::PH_HDR_HI:
                begin
                    head_hi = b;
                    phase   = lft_pkg::PH_HDR_LO;
                end
                lft_pkg::PH_HDR_LO:
                begin
                    kind        = head_hi[7:1];
                    tlen        = {head_hi[0], b};
                    remain      = tlen;
                    value_bytes = '0;
                    if (kind == lft_pkg::TLV_END)
                    begin
                        stopped = 1'b1;
                        phase   = lft_pkg::PH_HDR_HI;
                    end
                    else if (tlen == '0)
                        close_tlv();
                    else
                        phase = lft_pkg::PH_VALUE;
                end
                default:
                begin
                    if (tlen - remain < lft_pkg::KEEP_BYTES)
                        value_bytes = {value_bytes[55:0], b};
                    remain = remain - 9'd1;
                    if (remain == '0)
                        close_tlv();
                end
            endcase
        end
    endtask

    // one accepted frame byte; a final byte of a passing frame yields a summary
    task automatic take_frame_byte(input logic [7:0] b, input logic last);
        lft_pkg::result_t summary;
        int               p;
        p = int'(pos);
        if (p < MAX_FRAME_BYTES)
        begin
            if (pos < lft_pkg::POS_DA_END)
            begin
                if (b != want_dest[8*(5-p) +: 8])
                    hdr_ok = 1'b0;
            end
            else if (pos == lft_pkg::POS_ETYPE_HI)
            begin
                if (b != want_etype[15:8])
                    hdr_ok = 1'b0;
            end
            else if (pos == lft_pkg::POS_ETYPE_LO)
            begin
                if (b != want_etype[7:0])
                    hdr_ok = 1'b0;
            end
            else if (pos >= lft_pkg::HDR_BYTES)
            begin
                walk_tlv_byte(b);
            end
            pos = pos + 1'b1;
        end
        if (last)
        begin
            if (hdr_ok && pos >= lft_pkg::HDR_BYTES)
            begin
                summary.chassis_valid = chassis_ok;
                summary.chassis_mac   = chassis;
                summary.port_valid    = port_ok;
                summary.port_value    = port;
                summary.time_to_live  = ttl;
                expected_summaries.push_back(summary);
            end
            start_new_frame();
        end
    endtask

    task automatic compare_field(input string name, input logic [47:0] want,
                                 input logic [47:0] seen);
        if (want !== seen)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
        end
    endtask

    task automatic check_summary(input lft_pkg::result_t got);
        lft_pkg::result_t want;
        if (expected_summaries.size() == 0)
        begin
            mismatches++;
            $display("%0t: summary with none pending, expected nothing actual %h",
                     $time, got);
        end
        else
        begin
            want = expected_summaries.pop_front();
            compare_field("chassis_valid", 48'(want.chassis_valid), 48'(got.chassis_valid));
            compare_field("chassis_mac", want.chassis_mac, got.chassis_mac);
            compare_field("port_valid", 48'(want.port_valid), 48'(got.port_valid));
            compare_field("port_value", 48'(want.port_value), 48'(got.port_value));
            compare_field("time_to_live", 48'(want.time_to_live), 48'(got.time_to_live));
        end
    endtask

    // sample every transfer and register write at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_etype = lft_pkg::ETHERTYPE_RST;
            want_dest  = lft_pkg::DEST_ADDR_RST;
            start_new_frame();
            expected_summaries.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == lft_pkg::CFG_ETHERTYPE)
                    want_etype = cfg_wr_data[15:0];
                else if (cfg_index == lft_pkg::CFG_DEST_ADDR)
                    want_dest = cfg_wr_data;
            end
            if (m_tvalid && m_tready)
                check_summary(m_tdata[$bits(lft_pkg::result_t)-1:0]);
            if (s_tvalid && s_tready)
                take_frame_byte(s_tdata, s_tlast);
            outstanding = expected_summaries.size();
        end
    end

endmodule

### bench/lldp_frame_tlv_extractor_top_tb.sv
// testbench top for the lldp tlv extractor: frame stimulus, idling and verdict
module lldp_frame_tlv_extractor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAME_BYTES = 1600;
    localparam logic [6:0] TLV_FIRST_SPARE = 7'd4;
    localparam logic [6:0] TLV_KIND_MAX    = 7'd127;
    localparam logic [6:0] TLV_FILLER      = 7'd10;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [lft_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [47:0]                   cfg_wr_data = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata     = '0;
    logic                          s_tlast     = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [103:0]                  m_tdata;

    int mismatches;
    int outstanding;

    // stimulus state
    int          src_idle_pct   = 29;
    int          sink_stall_pct = 55;
    int          bytes_sent     = 0;
    logic [15:0] cur_etype      = lft_pkg::ETHERTYPE_RST;
    logic [47:0] cur_dest       = lft_pkg::DEST_ADDR_RST;
    logic [7:0]  frame_bytes[$];

    lldp_frame_tlv_extractor_top #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    lldp_summary_checker #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);

    // run limit
    initial
    begin
        #(5ms);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic put_byte(input logic [7:0] b);
        frame_bytes.push_back(b);
    endtask

    task automatic put_random_bytes(input int n);
        repeat (n) frame_bytes.push_back(8'($urandom_range(255, 0)));
    endtask

    task automatic trim_frame(input int keep);
        while (frame_bytes.size() > keep)
            void'(frame_bytes.pop_back());
    endtask

    // destination, random source, ethertype; a failing field gets one bit flipped
    task automatic put_header(input logic dest_ok, input logic type_ok);
        logic [47:0] da;
        logic [15:0] et;
        da = cur_dest;
        et = cur_etype;
        if (!dest_ok)
            da = da ^ (48'd1 << $urandom_range(47, 0));
        if (!type_ok)
            et = et ^ (16'd1 << $urandom_range(15, 0));
        for (int i = 5; i >= 0; i--)
            put_byte(da[8*i +: 8]);
        put_random_bytes(6);
        put_byte(et[15:8]);
        put_byte(et[7:0]);
    endtask

    task automatic put_tlv_head(input logic [6:0] kind, input int len);
        logic [8:0] l;
        l = 9'(len);
        put_byte({kind, l[8]});
        put_byte(l[7:0]);
    endtask

    // chassis or port id tlv: subtype then random id bytes
    task automatic put_id_tlv(input logic [6:0] kind, input int len, input logic [7:0] sub);
        put_tlv_head(kind, len);
        if (len > 0)
        begin
            put_byte(sub);
            put_random_bytes(len - 1);
        end
    endtask

    task automatic put_random_tlv();
        int         pick;
        int         len;
        logic [7:0] sub;
        pick = $urandom_range(99, 0);
        if (pick < 22)
        begin
            len = ($urandom_range(3, 0) == 0) ? $urandom_range(6, 0) : $urandom_range(12, 7);
            sub = ($urandom_range(4, 0) == 0) ? 8'($urandom_range(255, 0)) :
                  lft_pkg::CHASSIS_SUB_MAC;
            put_id_tlv(lft_pkg::TLV_CHASSIS, len, sub);
        end
        else if (pick < 44)
        begin
            len = ($urandom_range(3, 0) == 0) ? $urandom_range(4, 0) : $urandom_range(10, 5);
            sub = ($urandom_range(4, 0) == 0) ? 8'($urandom_range(255, 0)) :
                  lft_pkg::PORT_SUB_ID;
            put_id_tlv(lft_pkg::TLV_PORT, len, sub);
        end
        else if (pick < 66)
        begin
            len = ($urandom_range(3, 0) == 0) ? $urandom_range(4, 0) : 2;
            put_tlv_head(lft_pkg::TLV_TTL, len);
            put_random_bytes(len);
        end
        else if (pick < 95)
        begin
            len = ($urandom_range(19, 0) == 0) ? $urandom_range(300, 256) : $urandom_range(20, 0);
            put_tlv_head(7'($urandom_range(TLV_KIND_MAX, TLV_FIRST_SPARE)), len);
            put_random_bytes(len);
        end
        else
        begin
            // end marker in mid frame, with any length
            put_tlv_head(lft_pkg::TLV_END, $urandom_range(511, 0));
        end
    endtask

    // frame running past the size bound; ttl completes just inside it
    task automatic build_oversized_frame();
        frame_bytes.delete();
        put_header(1'b1, 1'b1);
        repeat (3)
        begin
            put_tlv_head(TLV_FILLER, 511);
            put_random_bytes(511);
        end
        put_tlv_head(TLV_FILLER, 40);
        put_random_bytes(40);
        put_tlv_head(lft_pkg::TLV_TTL, 2);
        put_byte(8'hA5);
        put_byte(8'h5A);
        put_id_tlv(lft_pkg::TLV_CHASSIS, 7, lft_pkg::CHASSIS_SUB_MAC);
        put_random_bytes($urandom_range(30, 1));
    endtask

    task automatic build_random_frame();
        int pick;
        pick = $urandom_range(99, 0);
        frame_bytes.delete();
        if (pick < 82)
        begin
            if (pick < 70)
                put_header(1'b1, 1'b1);
            else if (pick < 76)
                put_header(1'b0, 1'b1);
            else
                put_header(1'b1, 1'b0);
            repeat ($urandom_range(5, 0)) put_random_tlv();
            if ($urandom_range(9, 0) < 7)
                put_tlv_head(lft_pkg::TLV_END, 0);
            put_random_bytes($urandom_range(3, 0));
            // cut short now and then
            if ($urandom_range(6, 0) == 0)
                trim_frame($urandom_range(frame_bytes.size() - 1, 1));
        end
        else if (pick < 90)
        begin
            put_header(1'b1, 1'b1);
            trim_frame($urandom_range(13, 1));
        end
        else if (pick < 99)
        begin
            put_random_bytes($urandom_range(40, 1));
        end
        else
        begin
            build_oversized_frame();
        end
    endtask

    // one transfer per byte, source idling at random before each
    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            while ($urandom_range(99, 0) < src_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_bytes[i];
            s_tlast  <= (i == frame_bytes.size() - 1);
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
        bytes_sent += frame_bytes.size();
    endtask

    // stop the source and let every pending summary and the pipeline drain
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_register(input logic [lft_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [47:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == lft_pkg::CFG_ETHERTYPE)
            cur_etype = data[15:0];
        else
            cur_dest = data;
    endtask

    function automatic logic [47:0] random_word();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // main sequence
    initial
    begin
        int round_start_bytes;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames at the reset settings
        // all three ids at their extremes, then end
        frame_bytes.delete();
        put_header(1'b1, 1'b1);
        put_tlv_head(lft_pkg::TLV_CHASSIS, 7);
        put_byte(lft_pkg::CHASSIS_SUB_MAC);
        repeat (6) put_byte(8'hFF);
        put_tlv_head(lft_pkg::TLV_PORT, 5);
        put_byte(lft_pkg::PORT_SUB_ID);
        repeat (4) put_byte(8'h00);
        put_tlv_head(lft_pkg::TLV_TTL, 2);
        put_byte(8'hFF);
        put_byte(8'hFF);
        put_tlv_head(lft_pkg::TLV_END, 0);
        send_frame();

        // longer id tlvs, zero ttl, no end marker
        frame_bytes.delete();
        put_header(1'b1, 1'b1);
        put_id_tlv(lft_pkg::TLV_CHASSIS, 9, lft_pkg::CHASSIS_SUB_MAC);
        put_id_tlv(lft_pkg::TLV_PORT, 8, lft_pkg::PORT_SUB_ID);
        put_tlv_head(lft_pkg::TLV_TTL, 2);
        put_byte(8'h00);
        put_byte(8'h00);
        send_frame();

        // bare header, then one byte too short
        frame_bytes.delete();
        put_header(1'b1, 1'b1);
        send_frame();
        frame_bytes.delete();
        put_header(1'b1, 1'b1);
        trim_frame(13);
        send_frame();

        // wrong address, wrong ethertype
        frame_bytes.delete();
        put_header(1'b0, 1'b1);
        put_id_tlv(lft_pkg::TLV_CHASSIS, 7, lft_pkg::CHASSIS_SUB_MAC);
        send_frame();
        frame_bytes.delete();
        put_header(1'b1, 1'b0);
        put_id_tlv(lft_pkg::TLV_CHASSIS, 7, lft_pkg::CHASSIS_SUB_MAC);
        send_frame();

        // id tlvs too short or of the wrong subtype, malformed ttls
        frame_bytes.delete();
        put_header(1'b1, 1'b1);
        put_id_tlv(lft_pkg::TLV_CHASSIS, 6, lft_pkg::CHASSIS_SUB_MAC);
        put_id_tlv(lft_pkg::TLV_PORT, 4, lft_pkg::PORT_SUB_ID);
        put_id_tlv(lft_pkg::TLV_CHASSIS, 7, lft_pkg::CHASSIS_SUB_MAC + 8'd1);
        put_id_tlv(lft_pkg::TLV_PORT, 5, lft_pkg::PORT_SUB_ID - 8'd1);
        put_tlv_head(lft_pkg::TLV_TTL, 3);
        put_random_bytes(3);
        put_tlv_head(lft_pkg::TLV_TTL, 1);
        put_random_bytes(1);
        put_tlv_head(lft_pkg::TLV_END, 0);
        send_frame();

        // good chassis, then a second one cut off by the frame end
        frame_bytes.delete();
        put_header(1'b1, 1'b1);
        put_id_tlv(lft_pkg::TLV_CHASSIS, 7, lft_pkg::CHASSIS_SUB_MAC);
        put_id_tlv(lft_pkg::TLV_CHASSIS, 7, lft_pkg::CHASSIS_SUB_MAC);
        trim_frame(frame_bytes.size() - 4);
        send_frame();

        // anything after the end marker is ignored
        frame_bytes.delete();
        put_header(1'b1, 1'b1);
        put_tlv_head(lft_pkg::TLV_END, 0);
        put_id_tlv(lft_pkg::TLV_CHASSIS, 7, lft_pkg::CHASSIS_SUB_MAC);
        put_id_tlv(lft_pkg::TLV_PORT, 5, lft_pkg::PORT_SUB_ID);
        send_frame();

        // empty tlvs, a good port, then a maximum-length tlv left unfinished
        frame_bytes.delete();
        put_header(1'b1, 1'b1);
        put_tlv_head(TLV_KIND_MAX, 0);
        put_tlv_head(lft_pkg::TLV_CHASSIS, 0);
        put_tlv_head(lft_pkg::TLV_TTL, 0);
        put_id_tlv(lft_pkg::TLV_PORT, 5, lft_pkg::PORT_SUB_ID);
        put_tlv_head(TLV_KIND_MAX, 511);
        put_random_bytes(20);
        send_frame();

        // later tlvs of a kind replace earlier ones; a bad ttl keeps the old one
        frame_bytes.delete();
        put_header(1'b1, 1'b1);
        put_id_tlv(lft_pkg::TLV_CHASSIS, 7, lft_pkg::CHASSIS_SUB_MAC);
        put_id_tlv(lft_pkg::TLV_PORT, 6, lft_pkg::PORT_SUB_ID);
        put_tlv_head(lft_pkg::TLV_TTL, 2);
        put_random_bytes(2);
        put_id_tlv(lft_pkg::TLV_CHASSIS, 8, lft_pkg::CHASSIS_SUB_MAC);
        put_id_tlv(lft_pkg::TLV_PORT, 5, lft_pkg::PORT_SUB_ID);
        put_tlv_head(lft_pkg::TLV_TTL, 3);
        put_random_bytes(3);
        put_tlv_head(lft_pkg::TLV_END, 0);
        send_frame();

        // size bound, then a single-byte frame
        build_oversized_frame();
        send_frame();
        frame_bytes.delete();
        put_random_bytes(1);
        send_frame();

        // random rounds, new register settings between them
        for (int round = 0; round < 6; round++)
        begin
            case (round / 2)
                0:
                begin
                    src_idle_pct   = 29;
                    sink_stall_pct = 55;
                end
                1:
                begin
                    src_idle_pct   = 55;
                    sink_stall_pct = 29;
                end
                default:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            drain_block();
            case (round)
                0:
                begin
                    write_register(lft_pkg::CFG_ETHERTYPE, '1);
                    write_register(lft_pkg::CFG_DEST_ADDR, '1);
                end
                1:
                begin
                    write_register(lft_pkg::CFG_ETHERTYPE, '0);
                    write_register(lft_pkg::CFG_DEST_ADDR, '0);
                end
                4:
                begin
                    write_register(lft_pkg::CFG_ETHERTYPE,
                                   {random_word()} & ~48'hFFFF | lft_pkg::ETHERTYPE_RST);
                    write_register(lft_pkg::CFG_DEST_ADDR, random_word());
                end
                5:
                begin
                    write_register(lft_pkg::CFG_ETHERTYPE, random_word());
                end
                default:
                begin
                    write_register(lft_pkg::CFG_ETHERTYPE, random_word());
                    write_register(lft_pkg::CFG_DEST_ADDR, random_word());
                end
            endcase
            round_start_bytes = bytes_sent;
            while (bytes_sent - round_start_bytes < 175)
            begin
                build_random_frame();
                send_frame();
            end
        end

        // wait for the last summaries, then the verdict
        drain_block();
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
